@@ src/cartesian_grid_rank_map_macros.svh @@
// Assertion macros used by the rank map top level.
`ifndef CARTESIAN_GRID_RANK_MAP_MACROS_SVH
`define CARTESIAN_GRID_RANK_MAP_MACROS_SVH
`ifndef SYNTHESIS
`define CGRM_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cgrm check failed");
`define CGRM_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cgrm check failed");
`else
`define CGRM_CHECK(lbl, ante, cons)
`define CGRM_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/cgrm_pkg.sv @@
// Shared types, constants and helpers of the Cartesian grid rank map.
package cgrm_pkg;

  localparam int MAX_DIMS  = 4;
  localparam int DIM_BITS  = 16;
  localparam int LANES     = 4;
  localparam int DIV_STEPS = 33;
  localparam int SEGS      = 5;
  localparam int TAIL      = 3;
  localparam int LATENCY   = SEGS * (DIV_STEPS + 1) + TAIL;

  typedef enum logic [1:0] {
    KIND_R2C   = 2'd0,
    KIND_C2R   = 2'd1,
    KIND_SHIFT = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_DIMS = 2'd1,
    ST_BAD_DIR = 2'd2
  } status_t;

  localparam logic [2:0] REG_NUM_DIMS   = 3'd0;
  localparam logic [2:0] REG_DIM_SIZES  = 3'd1;
  localparam logic [2:0] REG_PERIODIC   = 3'd2;
  localparam logic [2:0] REG_OWN_POS    = 3'd3;
  localparam logic [2:0] REG_OWN_RANK   = 3'd4;
  localparam logic [2:0] REG_NODE_COUNT = 3'd5;

  typedef struct packed {
    logic [2:0]                               nd;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0]        sizes;
    logic [MAX_DIMS-1:0]                      per;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0]        pos;
    logic [31:0]                              own_rank;
    logic [31:0]                              nodes;
  } cfg_t;

  // one restoring divider lane: partial remainder, dividend/quotient, divisor
  typedef struct packed {
    logic        act;
    logic [31:0] r;
    logic [32:0] q;
    logic [31:0] d;
  } lane_t;

  typedef struct packed {
    logic                              valid;
    kind_t                             kind;
    logic [31:0]                       rank;
    logic [MAX_DIMS-1:0][31:0]         coord;
    logic [3:0]                        dir;
    logic [31:0]                       disp;
    lane_t [LANES-1:0]                 lane;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] hold;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] cout;
    logic                              nn_zero;
  } word_t;

  typedef struct packed {
    logic                              valid;
    logic [31:0]                       rank_result;
    logic [MAX_DIMS-1:0][DIM_BITS-1:0] coord;
    logic [31:0]                       src_rank;
    logic                              src_null;
    logic [31:0]                       dst_rank;
    logic                              dst_null;
    status_t                           status;
  } res_t;

  function automatic logic [2:0] dims_used(input logic [2:0] nd);
    return (nd > 3'(MAX_DIMS)) ? 3'(MAX_DIMS) : nd;
  endfunction

  function automatic lane_t mk_lane(input logic [32:0] dvd, input logic [31:0] dvs);
    lane_t l;
    l.act = 1'b1;
    l.r   = '0;
    l.q   = dvd;
    l.d   = dvs;
    return l;
  endfunction

  function automatic logic [32:0] abs33(input logic [33:0] v);
    logic [33:0] n;
    n = ~v + 34'd1;
    return v[33] ? n[32:0] : v[32:0];
  endfunction

  // own position moved by +disp (sub=0) or -disp (sub=1), 34-bit signed
  function automatic logic [33:0] shift_pos(input logic [DIM_BITS-1:0] p,
                                            input logic [31:0] disp, input logic sub);
    logic [33:0] px;
    logic [33:0] dx;
    px = {18'd0, p};
    dx = {{2{disp[31]}}, disp};
    return sub ? (px - dx) : (px + dx);
  endfunction

endpackage

@@ src/cartesian_grid_rank_map.sv @@
// Top level of the Cartesian grid rank map: config registers, divider chain, fold tail.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------------
//  request  | start, busy         | in_kind, in_rank_query, in_coord_0..3,
//           |                     | in_direction, in_displacement
//  result   | out_valid (strobe)  | out_rank_result, out_coord_0..3, out_source_rank,
//           |                     | out_source_null, out_dest_rank, out_dest_null,
//           |                     | out_status
//  config   | cfg_we              | cfg_index, cfg_wdata
//
// A word is taken every cycle busy is low; busy is high only in reset.
// Each word passes five segments of a seam stage plus 33 restoring-division cells each,
// then three fold stages (modulo fix-up, multiply, sum). The division cell chain sets
// the latency; throughput is one word per cycle while busy is low. Every word yields
// exactly one result strobe; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the chain and restores the config defaults.
`include "cartesian_grid_rank_map_macros.svh"

module cartesian_grid_rank_map (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_rank_query,
  input  logic [31:0] in_coord_0,
  input  logic [31:0] in_coord_1,
  input  logic [31:0] in_coord_2,
  input  logic [31:0] in_coord_3,
  input  logic [3:0]  in_direction,
  input  logic [31:0] in_displacement,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output logic        out_valid,
  output logic [31:0] out_rank_result,
  output logic [15:0] out_coord_0,
  output logic [15:0] out_coord_1,
  output logic [15:0] out_coord_2,
  output logic [15:0] out_coord_3,
  output logic [31:0] out_source_rank,
  output logic        out_source_null,
  output logic [31:0] out_dest_rank,
  output logic        out_dest_null,
  output logic [1:0]  out_status
);

  localparam int STEPS = cgrm_pkg::DIV_STEPS;
  localparam int SEGS  = cgrm_pkg::SEGS;

  // configuration registers
  logic [2:0]  num_dims_r;
  logic [63:0] dim_sizes_r;
  logic [3:0]  periodic_r;
  logic [63:0] own_pos_r;
  logic [31:0] own_rank_r;
  logic [31:0] node_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r   <= '0;
      dim_sizes_r  <= '0;
      periodic_r   <= '0;
      own_pos_r    <= '0;
      own_rank_r   <= '0;
      node_count_r <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cgrm_pkg::REG_NUM_DIMS:   num_dims_r   <= cfg_wdata[2:0];
        cgrm_pkg::REG_DIM_SIZES:  dim_sizes_r  <= cfg_wdata;
        cgrm_pkg::REG_PERIODIC:   periodic_r   <= cfg_wdata[3:0];
        cgrm_pkg::REG_OWN_POS:    own_pos_r    <= cfg_wdata;
        cgrm_pkg::REG_OWN_RANK:   own_rank_r   <= cfg_wdata[31:0];
        cgrm_pkg::REG_NODE_COUNT: node_count_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  cgrm_pkg::cfg_t cfg;
  assign cfg.nd       = num_dims_r;
  assign cfg.sizes    = dim_sizes_r;
  assign cfg.per      = periodic_r;
  assign cfg.pos      = own_pos_r;
  assign cfg.own_rank = own_rank_r;
  assign cfg.nodes    = node_count_r;

  // request entry
  logic            in_acc;
  cgrm_pkg::word_t entry;

  assign busy   = !rst_n;
  assign in_acc = start && !busy;

  always_comb begin
    entry          = '0;
    entry.valid    = in_acc;
    entry.kind     = cgrm_pkg::kind_t'(in_kind);
    entry.rank     = in_rank_query;
    entry.coord    = {in_coord_3, in_coord_2, in_coord_1, in_coord_0};
    entry.dir      = in_direction;
    entry.disp     = in_displacement;
  end

  // divider chain: per segment one seam, then STEPS single-bit cells
  cgrm_pkg::word_t seam_in [SEGS];
  cgrm_pkg::word_t seg_w   [SEGS][STEPS+1];

  assign seam_in[0] = entry;

  for (genvar k = 0; k < SEGS; k++) begin : g_seg
    if (k > 0) begin : g_link
      assign seam_in[k] = seg_w[k-1][STEPS];
    end
    cgrm_seam u_seam (
      .clk   (clk),
      .rst_n (rst_n),
      .seg   (3'(k)),
      .cfg   (cfg),
      .w_in  (seam_in[k]),
      .w_out (seg_w[k][0])
    );
    for (genvar j = 0; j < STEPS; j++) begin : g_cell
      cgrm_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .w_in  (seg_w[k][j]),
        .w_out (seg_w[k][j+1])
      );
    end
  end

  cgrm_pkg::res_t res;

  cgrm_fold u_fold (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .w_in  (seg_w[SEGS-1][STEPS]),
    .res   (res)
  );

  assign out_valid       = res.valid;
  assign out_rank_result = res.rank_result;
  assign out_coord_0     = res.coord[0];
  assign out_coord_1     = res.coord[1];
  assign out_coord_2     = res.coord[2];
  assign out_coord_3     = res.coord[3];
  assign out_source_rank = res.src_rank;
  assign out_source_null = res.src_null;
  assign out_dest_rank   = res.dst_rank;
  assign out_dest_null   = res.dst_null;
  assign out_status      = res.status;

  // error results carry nothing else
  `CGRM_CHECK(a_err_clean, out_valid && out_status != cgrm_pkg::ST_OK, out_source_rank == '0 && out_dest_rank == '0 && !out_source_null && !out_dest_null)
  // a null neighbor has no rank
  `CGRM_CHECK(a_null_rank, out_valid && (out_dest_null || out_source_null), (!out_dest_null || out_dest_rank == '0) && (!out_source_null || out_source_rank == '0))
  // decomposed coordinates only come with a plain result
  `CGRM_CHECK(a_coord_only, out_valid && (out_coord_0 != '0 || out_coord_3 != '0), out_rank_result == '0 && out_status == cgrm_pkg::ST_OK && !out_dest_null)

endmodule

@@ src/cgrm_cell.sv @@
// One divider cell: a single restoring step on every active lane.
module cgrm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  cgrm_pkg::word_t   w_in,
  output cgrm_pkg::word_t   w_out
);

  cgrm_pkg::word_t w_r;
  cgrm_pkg::word_t w_nxt;

  always_comb begin
    logic [32:0] trial;
    logic        ge;
    w_nxt = w_in;
    for (int l = 0; l < cgrm_pkg::LANES; l++) begin
      trial = {w_in.lane[l].r, w_in.lane[l].q[32]};
      ge    = trial >= {1'b0, w_in.lane[l].d};
      if (w_in.lane[l].act) begin
        w_nxt.lane[l].r = ge ? 32'(trial - {1'b0, w_in.lane[l].d}) : trial[31:0];
        w_nxt.lane[l].q = {w_in.lane[l].q[31:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (!rst_n) begin
      w_r.valid <= 1'b0;
    end
  end

  assign w_out = w_r;

endmodule

@@ src/cgrm_seam.sv @@
// Segment boundary: collects finished divider results and loads the next divisions.
module cgrm_seam (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        seg,
  input  cgrm_pkg::cfg_t    cfg,
  input  cgrm_pkg::word_t   w_in,
  output cgrm_pkg::word_t   w_out
);

  cgrm_pkg::word_t w_r;
  cgrm_pkg::word_t w_nxt;

  always_comb begin
    logic [31:0] nn;
    logic [31:0] rem;
    logic [1:0]  kidx;
    logic [1:0]  pidx;
    logic [1:0]  didx;
    w_nxt = w_in;
    nn    = '0;
    rem   = '0;
    kidx  = seg[1:0];
    pidx  = 2'(seg - 3'd1);
    didx  = w_in.dir[1:0];
    if (seg == 3'd0) begin
      for (int l = 0; l < cgrm_pkg::LANES; l++) begin
        w_nxt.lane[l] = '0;
      end
      unique case (w_in.kind)
        cgrm_pkg::KIND_R2C: begin
          w_nxt.lane[0] = cgrm_pkg::mk_lane({1'b0, cfg.nodes}, {16'd0, cfg.sizes[0]});
        end
        cgrm_pkg::KIND_C2R: begin
          for (int l = 0; l < cgrm_pkg::LANES; l++) begin
            w_nxt.lane[l] = cgrm_pkg::mk_lane(
                cgrm_pkg::abs33({{2{w_in.coord[l][31]}}, w_in.coord[l]}),
                {16'd0, cfg.sizes[l]});
          end
        end
        cgrm_pkg::KIND_SHIFT: begin
          for (int l = 0; l < cgrm_pkg::LANES; l++) begin
            w_nxt.lane[l] = cgrm_pkg::mk_lane({17'd0, cfg.pos[l]}, {16'd0, cfg.sizes[l]});
          end
        end
        default: ;
      endcase
    end else begin
      unique case (w_in.kind)
        cgrm_pkg::KIND_R2C: begin
          // node count left after dividing out the previous dimension
          nn = (cfg.sizes[pidx] == '0) ? '0 : w_in.lane[0].q[31:0];
          if (seg >= 3'd2) begin
            w_nxt.cout[2'(seg - 3'd2)] = w_in.nn_zero ? '0 : w_in.lane[1].q[15:0];
            rem = w_in.lane[1].r;
          end else begin
            rem = w_in.rank;
          end
          w_nxt.lane[1] = cgrm_pkg::mk_lane({1'b0, rem}, nn);
          if (seg < 3'd4) begin
            w_nxt.lane[0] = cgrm_pkg::mk_lane({1'b0, nn}, {16'd0, cfg.sizes[kidx]});
          end else begin
            w_nxt.lane[0] = '0;
          end
          w_nxt.nn_zero = (nn == '0);
        end
        cgrm_pkg::KIND_C2R, cgrm_pkg::KIND_SHIFT: begin
          if (seg == 3'd1) begin
            for (int l = 0; l < cgrm_pkg::LANES; l++) begin
              w_nxt.hold[l] = w_in.lane[l].r[15:0];
              w_nxt.lane[l] = '0;
            end
            if (w_in.kind == cgrm_pkg::KIND_SHIFT) begin
              w_nxt.lane[0] = cgrm_pkg::mk_lane(cgrm_pkg::abs33(
                  cgrm_pkg::shift_pos(cfg.pos[didx], w_in.disp, 1'b0)),
                  {16'd0, cfg.sizes[didx]});
              w_nxt.lane[1] = cgrm_pkg::mk_lane(cgrm_pkg::abs33(
                  cgrm_pkg::shift_pos(cfg.pos[didx], w_in.disp, 1'b1)),
                  {16'd0, cfg.sizes[didx]});
            end
          end else begin
            // shifted-position divisions are done: park the lanes to the tail
            for (int l = 0; l < cgrm_pkg::LANES; l++) begin
              w_nxt.lane[l].act = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (!rst_n) begin
      w_r.valid <= 1'b0;
    end
  end

  assign w_out = w_r;

endmodule

@@ src/cgrm_fold.sv @@
// Tail: modulo fix-up, place-value multiplies and rank sums, result register.
module cgrm_fold (
  input  logic              clk,
  input  logic              rst_n,
  input  cgrm_pkg::cfg_t    cfg,
  input  cgrm_pkg::word_t   w_in,
  output cgrm_pkg::res_t    res
);

  typedef struct packed {
    logic                     valid;
    cgrm_pkg::kind_t          kind;
    cgrm_pkg::status_t        status;
    logic                     zero_disp;
    logic                     dnull;
    logic                     snull;
    logic [3:0][15:0]         cout;
  } ctl_t;

  function automatic logic [31:0] fix_mod(input logic [15:0] m, input logic neg,
                                          input logic [15:0] s);
    return (neg && (m != '0)) ? {16'd0, 16'(s - m)} : {16'd0, m};
  endfunction

  ctl_t              s1_r, s1_nxt, s2_r;
  logic [3:0][31:0]  opa_r, opa_nxt, opb_r, opb_nxt;
  logic [3:0][31:0]  pa_r, pa_nxt, pb_r, pb_nxt;
  logic [3:0][31:0]  mult;
  logic [15:0]       e1, e2, e3;
  logic [31:0]       m1_r, m1_nxt, m0_r, m0_nxt;
  cgrm_pkg::res_t    res_r, res_nxt;
  logic [2:0]        nd;

  assign nd = cgrm_pkg::dims_used(cfg.nd);

  // place values, last dimension fastest
  assign e1     = (nd > 3'd1) ? cfg.sizes[1] : 16'd1;
  assign e2     = (nd > 3'd2) ? cfg.sizes[2] : 16'd1;
  assign e3     = (nd > 3'd3) ? cfg.sizes[3] : 16'd1;
  assign m1_nxt = {16'd0, e3} * {16'd0, e2};
  assign m0_nxt = m1_r * {16'd0, e1};
  assign mult   = {32'd1, {16'd0, e3}, m1_r, m0_r};

  always_comb begin
    logic [1:0]  di;
    logic [15:0] sd;
    logic [33:0] vp, vm;
    logic [31:0] wp, wm;
    logic [3:0][31:0] base;
    di = w_in.dir[1:0];
    sd = cfg.sizes[di];
    vp = cgrm_pkg::shift_pos(cfg.pos[di], w_in.disp, 1'b0);
    vm = cgrm_pkg::shift_pos(cfg.pos[di], w_in.disp, 1'b1);
    wp = (cfg.per[di] && sd != '0) ? fix_mod(w_in.lane[0].r[15:0], vp[33], sd) : vp[31:0];
    wm = (cfg.per[di] && sd != '0) ? fix_mod(w_in.lane[1].r[15:0], vm[33], sd) : vm[31:0];
    s1_nxt.valid     = w_in.valid;
    s1_nxt.kind      = w_in.kind;
    s1_nxt.zero_disp = (w_in.disp == '0);
    s1_nxt.dnull     = !cfg.per[di] && (vp[33] || vp[32:0] >= {17'd0, sd});
    s1_nxt.snull     = !cfg.per[di] && (vm[33] || vm[32:0] >= {17'd0, sd});
    if (nd == 3'd0) begin
      s1_nxt.status = cgrm_pkg::ST_NO_DIMS;
    end else if (w_in.dir >= {1'b0, nd}) begin
      s1_nxt.status = cgrm_pkg::ST_BAD_DIR;
    end else begin
      s1_nxt.status = cgrm_pkg::ST_OK;
    end
    s1_nxt.cout    = w_in.cout;
    s1_nxt.cout[3] = w_in.nn_zero ? '0 : w_in.lane[1].q[15:0];
    for (int i = 0; i < cgrm_pkg::MAX_DIMS; i++) begin
      if (3'(i) >= nd) begin
        s1_nxt.cout[i] = '0;
      end
      base[i] = cfg.per[i] ? {16'd0, w_in.hold[i]} : {16'd0, cfg.pos[i]};
      if (w_in.kind == cgrm_pkg::KIND_C2R) begin
        opa_nxt[i] = (cfg.per[i] && cfg.sizes[i] != '0) ?
            fix_mod(w_in.hold[i], w_in.coord[i][31], cfg.sizes[i]) : w_in.coord[i];
        opb_nxt[i] = '0;
      end else begin
        opa_nxt[i] = (2'(i) == di) ? wp : base[i];
        opb_nxt[i] = (2'(i) == di) ? wm : base[i];
      end
      if (3'(i) >= nd) begin
        opa_nxt[i] = '0;
        opb_nxt[i] = '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < cgrm_pkg::MAX_DIMS; i++) begin
      pa_nxt[i] = mult[i] * opa_r[i];
      pb_nxt[i] = mult[i] * opb_r[i];
    end
  end

  always_comb begin
    logic [31:0] sa, sb;
    sa = pa_r[0] + pa_r[1] + pa_r[2] + pa_r[3];
    sb = pb_r[0] + pb_r[1] + pb_r[2] + pb_r[3];
    res_nxt       = '0;
    res_nxt.valid = s2_r.valid;
    unique case (s2_r.kind)
      cgrm_pkg::KIND_R2C: res_nxt.coord = s2_r.cout;
      cgrm_pkg::KIND_C2R: res_nxt.rank_result = sa;
      cgrm_pkg::KIND_SHIFT: begin
        res_nxt.status = s2_r.status;
        if (s2_r.status == cgrm_pkg::ST_OK) begin
          if (s2_r.zero_disp) begin
            res_nxt.src_rank = cfg.own_rank;
            res_nxt.dst_rank = cfg.own_rank;
          end else begin
            res_nxt.dst_null = s2_r.dnull;
            res_nxt.src_null = s2_r.snull;
            res_nxt.dst_rank = s2_r.dnull ? '0 : sa;
            res_nxt.src_rank = s2_r.snull ? '0 : sb;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    m1_r  <= m1_nxt;
    m0_r  <= m0_nxt;
    s1_r  <= s1_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    s2_r  <= s1_r;
    pa_r  <= pa_nxt;
    pb_r  <= pb_nxt;
    res_r <= res_nxt;
    if (!rst_n) begin
      s1_r.valid  <= 1'b0;
      s2_r.valid  <= 1'b0;
      res_r.valid <= 1'b0;
    end
  end

  assign res = res_r;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the Cartesian grid rank map.
module testbench;

  // one request word as driven on the in_ ports
  typedef struct packed {
    cgrm_pkg::kind_t   kind;
    logic [31:0]       rank;
    logic [3:0][31:0]  coord;
    logic [3:0]        dir;
    logic [31:0]       disp;
  } query_t;

  // one result word as seen on the out_ ports
  typedef struct packed {
    logic [31:0]      rank_result;
    logic [3:0][15:0] coord;
    logic [31:0]      src_rank;
    logic             src_null;
    logic [31:0]      dst_rank;
    logic             dst_null;
    logic [1:0]       status;
  } answer_t;

  // Holds a copy of the grid registers, predicts answers, compares them in order.
  class GridScoreboard;
    logic [2:0]  num_dims;
    logic [63:0] sizes;
    logic [3:0]  wrap_mask;
    logic [63:0] own_pos;
    logic [31:0] own_rank;
    logic [31:0] nodes;
    answer_t     pending_answers[$];
    int          fails;

    function void clear();
      num_dims = 0; sizes = 0; wrap_mask = 0; own_pos = 0; own_rank = 0; nodes = 1;
      fails = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      unique case (idx)
        cgrm_pkg::REG_NUM_DIMS:   num_dims  = val[2:0];
        cgrm_pkg::REG_DIM_SIZES:  sizes     = val;
        cgrm_pkg::REG_PERIODIC:   wrap_mask = val[3:0];
        cgrm_pkg::REG_OWN_POS:    own_pos   = val;
        cgrm_pkg::REG_OWN_RANK:   own_rank  = val[31:0];
        cgrm_pkg::REG_NODE_COUNT: nodes     = val[31:0];
        default: ;
      endcase
    endfunction

    function int used_dims();
      return (num_dims > 4) ? 4 : int'(num_dims);
    endfunction

    function longint size_of(int i);
      return longint'(sizes[16*i +: 16]);
    endfunction

    // last dimension fastest; periodic dims reduced modulo size, negatives too
    function logic [31:0] fold_rank(longint c[4]);
      logic [31:0] r, mult;
      longint v, s;
      r = 0; mult = 1;
      for (int i = used_dims() - 1; i >= 0; i--) begin
        v = c[i];
        s = size_of(i);
        if (wrap_mask[i] && s != 0) begin
          v = v % s;
          if (v < 0) v += s;
        end
        r += mult * v[31:0];
        mult *= s[31:0];
      end
      return r;
    endfunction

    function void note(query_t q);
      answer_t a;
      int nd;
      logic [31:0] rem, nn, s32;
      longint p[4], v, s, disp;
      a = '0;
      nd = used_dims();
      unique case (q.kind)
        cgrm_pkg::KIND_R2C: begin
          rem = q.rank; nn = nodes;
          for (int i = 0; i < nd; i++) begin
            s32 = {16'd0, sizes[16*i +: 16]};
            nn = (s32 == 0) ? 0 : nn / s32;
            a.coord[i] = (nn == 0) ? 16'd0 : 16'(rem / nn);
            if (nn != 0) rem = rem % nn;
          end
        end
        cgrm_pkg::KIND_C2R: begin
          for (int i = 0; i < 4; i++) p[i] = longint'($signed(q.coord[i]));
          a.rank_result = fold_rank(p);
        end
        cgrm_pkg::KIND_SHIFT: begin
          disp = longint'($signed(q.disp));
          if (nd == 0) a.status = cgrm_pkg::ST_NO_DIMS;
          else if (int'(q.dir) >= nd) a.status = cgrm_pkg::ST_BAD_DIR;
          else if (disp == 0) begin
            a.src_rank = own_rank;
            a.dst_rank = own_rank;
          end else begin
            s = size_of(q.dir);
            for (int i = 0; i < 4; i++) p[i] = (i < nd) ? longint'(own_pos[16*i +: 16]) : 0;
            // destination: position plus displacement
            v = longint'(own_pos[16*q.dir +: 16]) + disp;
            p[q.dir] = v;
            if (!wrap_mask[q.dir] && (v >= s || v < 0)) a.dst_null = 1;
            else a.dst_rank = fold_rank(p);
            // source: position minus displacement
            v = longint'(own_pos[16*q.dir +: 16]) - disp;
            p[q.dir] = v;
            if (!wrap_mask[q.dir] && (v >= s || v < 0)) a.src_null = 1;
            else a.src_rank = fold_rank(p);
          end
        end
        default: ;
      endcase
      pending_answers.push_back(a);
    endfunction

    function void check(answer_t got);
      answer_t e;
      if (pending_answers.size() == 0) begin
        $error("result word with nothing outstanding");
        fails++;
        return;
      end
      e = pending_answers.pop_front();
      if (got.rank_result !== e.rank_result) begin
        $error("rank_result exp %0h got %0h", e.rank_result, got.rank_result); fails++;
      end
      for (int i = 0; i < 4; i++)
        if (got.coord[i] !== e.coord[i]) begin
          $error("out_coord_%0d exp %0h got %0h", i, e.coord[i], got.coord[i]); fails++;
        end
      if (got.src_rank !== e.src_rank) begin
        $error("source_rank exp %0h got %0h", e.src_rank, got.src_rank); fails++;
      end
      if (got.src_null !== e.src_null) begin
        $error("source_null exp %0b got %0b", e.src_null, got.src_null); fails++;
      end
      if (got.dst_rank !== e.dst_rank) begin
        $error("dest_rank exp %0h got %0h", e.dst_rank, got.dst_rank); fails++;
      end
      if (got.dst_null !== e.dst_null) begin
        $error("dest_null exp %0b got %0b", e.dst_null, got.dst_null); fails++;
      end
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); fails++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_kind = 0;
  logic [31:0] in_rank_query = 0;
  logic [31:0] in_coord_0 = 0, in_coord_1 = 0, in_coord_2 = 0, in_coord_3 = 0;
  logic [3:0]  in_direction = 0;
  logic [31:0] in_displacement = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = 0;
  logic [63:0] cfg_wdata = 0;
  logic        out_valid;
  logic [31:0] out_rank_result, out_source_rank, out_dest_rank;
  logic [15:0] out_coord_0, out_coord_1, out_coord_2, out_coord_3;
  logic        out_source_null, out_dest_null;
  logic [1:0]  out_status;

  GridScoreboard grid_sb = new();

  cartesian_grid_rank_map dut (.*);

  always #10 clk = ~clk;

  // results are strobes: sample the pre-edge values at each rising edge
  always @(posedge clk)
    if (rst_n && out_valid)
      grid_sb.check({out_rank_result, out_coord_3, out_coord_2, out_coord_1, out_coord_0,
                     out_source_rank, out_source_null, out_dest_rank, out_dest_null,
                     out_status});

  // watchdog: cycles with no word moving on either side
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("cartesian_grid_rank_map verification failed");
      $finish;
    end
  end

  bit allow_idle;

  // put one word up and hold it until the block takes it
  task automatic issue(query_t q);
    start           <= 1'b1;
    in_kind         <= q.kind;
    in_rank_query   <= q.rank;
    in_coord_0      <= q.coord[0];
    in_coord_1      <= q.coord[1];
    in_coord_2      <= q.coord[2];
    in_coord_3      <= q.coord[3];
    in_direction    <= q.dir;
    in_displacement <= q.disp;
    @(posedge clk);
    while (busy) @(posedge clk);
    grid_sb.note(q);
    // occasional idle gap of random length between words, when allow_idle is set
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // write enable stays up across a burst of writes; load_grid drops it
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    grid_sb.set_reg(idx, val);
  endtask

  // drop start and wait for every outstanding answer
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (grid_sb.pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_grid(logic [2:0] nd, logic [63:0] sz, logic [3:0] per,
                           logic [63:0] pos, logic [31:0] rk, logic [31:0] nn);
    write_reg(cgrm_pkg::REG_NUM_DIMS, {61'd0, nd});
    write_reg(cgrm_pkg::REG_DIM_SIZES, sz);
    write_reg(cgrm_pkg::REG_PERIODIC, {60'd0, per});
    write_reg(cgrm_pkg::REG_OWN_POS, pos);
    write_reg(cgrm_pkg::REG_OWN_RANK, {32'd0, rk});
    write_reg(cgrm_pkg::REG_NODE_COUNT, {32'd0, nn});
    cfg_we <= 1'b0;
  endtask

  // mostly small signed values near the grid, sometimes any 32-bit value
  function automatic logic [31:0] pick_word(int span);
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // random grid: usually small consistent sizes, sometimes zero or huge ones
  task automatic random_grid();
    logic [63:0] sz, pos;
    logic [31:0] prod;
    logic [15:0] s;
    logic [2:0]  nd;
    nd = 3'($urandom_range(0, 7));
    prod = 1; sz = 0; pos = 0;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 9))
        0: s = 16'd0;
        1: s = 16'($urandom);
        default: s = 16'($urandom_range(1, 9));
      endcase
      sz[16*i +: 16] = s;
      pos[16*i +: 16] = ($urandom_range(0, 5) == 0) ? 16'($urandom) :
                        ((s == 0) ? 16'd0 : 16'($urandom_range(0, s - 1)));
      if (i < nd) prod *= {16'd0, s};
    end
    load_grid(nd, sz, 4'($urandom), pos,
              ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200),
              ($urandom_range(0, 4) == 0) ? $urandom : prod);
  endtask

  function automatic query_t random_query();
    query_t q;
    q.kind  = cgrm_pkg::kind_t'(2'(($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, 2)));
    q.rank  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 300);
    for (int i = 0; i < 4; i++) q.coord[i] = pick_word(12);
    q.dir   = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
    q.disp  = pick_word(10);
    return q;
  endfunction

  task automatic directed_burst();
    query_t q;
    q = '0;
    q.kind = cgrm_pkg::KIND_R2C;  q.rank = 0;  issue(q);
    q.rank = '1;                               issue(q);
    q.rank = 32'h8000_0000;                    issue(q);
    q.kind = cgrm_pkg::KIND_C2R;  q.coord = '0; issue(q);
    q.coord = {4{32'h7FFF_FFFF}};              issue(q);
    q.coord = {4{32'h8000_0000}};              issue(q);
    q.coord = {4{32'hFFFF_FFFF}};              issue(q);
    q.coord = {32'd3, 32'hFFFF_FFF9, 32'd100, 32'd5}; issue(q);
    q.kind = cgrm_pkg::KIND_SHIFT; q.dir = 0; q.disp = 0; issue(q);
    q.disp = 1;                                issue(q);
    q.disp = 32'hFFFF_FFFF;                    issue(q);
    q.disp = 32'h7FFF_FFFF;                    issue(q);
    q.disp = 32'h8000_0000;                    issue(q);
    q.dir = 3; q.disp = 2;                     issue(q);
    q.dir = 15;                                issue(q);
    q.dir = 4;                                 issue(q);
    q.kind = cgrm_pkg::KIND_NONE; q.rank = '1; issue(q);
  endtask

  initial begin
    grid_sb.clear();
    allow_idle = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: zero dimensions, shift must report no dims
    directed_burst();
    drain();

    // typical 3x4x5 grid with mixed wrap
    load_grid(3'd3, {16'd0, 16'd5, 16'd4, 16'd3}, 4'b0101,
              {16'd0, 16'd4, 16'd0, 16'd2}, 32'd42, 32'd60);
    directed_burst();
    drain();

    // extremes: too many dims, maximum sizes, all periodic, all-ones position
    load_grid(3'd7, '1, 4'hF, '1, '1, '1);
    directed_burst();
    drain();

    // zero-size dimensions, nothing periodic
    load_grid(3'd4, {16'd2, 16'd0, 16'd3, 16'd0}, 4'h0, 64'd1, 32'd7, 32'd0);
    directed_burst();
    drain();

    // random grids, each one a pause until all answers are back
    for (int ph = 0; ph < 12; ph++) begin
      random_grid();
      allow_idle = (ph < 10);
      repeat (92) issue(random_query());
      drain();
    end

    repeat (cgrm_pkg::LATENCY + 20) @(posedge clk);
    if (grid_sb.pending_answers.size() != 0) begin
      $error("%0d answers never arrived", grid_sb.pending_answers.size());
      grid_sb.fails++;
    end
    if (grid_sb.fails == 0) begin
      $display("cartesian_grid_rank_map verification clean");
    end else begin
      $display("cartesian_grid_rank_map verification failed");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+src
src/cgrm_pkg.sv
src/cgrm_cell.sv
src/cgrm_seam.sv
src/cgrm_fold.sv
src/cartesian_grid_rank_map.sv
test/testbench.sv
